[hw/rtl/maps_pkg.sv]
// shared types and constants for the difference-equation plant
package maps_pkg;

  // counter field width, enough for any size up to eight
  localparam int CNT_W = 3;

  // item opcodes
  typedef enum logic [2:0] {
    OP_WR_A   = 3'd0,
    OP_WR_B   = 3'd1,
    OP_WR_OFS = 3'd2,
    OP_SET_IN = 3'd3,
    OP_PRESET = 3'd4,
    OP_TICK   = 3'd5
  } maps_op_t;

  // commands from controller to datapath
  typedef struct packed {
    logic             take;
    logic             acc_load;
    logic             issue;
    logic             sel_b;
    logic [CNT_W-1:0] lag;
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
    logic             emit;
    logic             last;
    logic             hist_shift;
  } maps_cmd_t;

endpackage

[hw/rtl/maps_ram.sv]
// generic single-write, single-read ram with registered read data
module maps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/maps_ctrl.sv]
// controller: sequences writes, the per-row product walk and result beats
module maps_ctrl #(
  parameter int NUM_OUTPUTS = 4,
  parameter int NUM_INPUTS  = 4,
  parameter int MODEL_ORDER = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         opcode,
  output logic               out_valid,
  input  logic               out_ready,
  output maps_pkg::maps_cmd_t cmd
);
  import maps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_ISSUE, S_DRAIN, S_EMIT, S_SHIFT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] row;
  logic [CNT_W-1:0] lag;
  logic [CNT_W-1:0] col;
  logic             sel_b;
  logic             drain;

  logic take;
  logic col_end;
  logic lag_end;
  logic row_end;
  logic slot_free;

  assign in_ready  = (state == S_IDLE);
  assign take      = in_valid && in_ready;
  assign col_end   = sel_b ? (32'(col) == NUM_INPUTS - 1) : (32'(col) == NUM_OUTPUTS - 1);
  assign lag_end   = (32'(lag) == MODEL_ORDER - 1);
  assign row_end   = (32'(row) == NUM_OUTPUTS - 1);
  assign slot_free = !out_valid || out_ready;

  // command decode
  always_comb begin
    cmd            = '0;
    cmd.take       = take;
    cmd.acc_load   = (state == S_LOAD);
    cmd.issue      = (state == S_ISSUE);
    cmd.sel_b      = sel_b;
    cmd.lag        = lag;
    cmd.row        = row;
    cmd.col        = col;
    cmd.emit       = (state == S_EMIT) && slot_free;
    cmd.last       = row_end;
    cmd.hist_shift = (state == S_SHIFT);
  end

  // state, counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row       <= '0;
      lag       <= '0;
      col       <= '0;
      sel_b     <= 1'b0;
      drain     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_EMIT && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take && opcode == OP_TICK) begin
            row   <= '0;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          lag   <= '0;
          col   <= '0;
          sel_b <= 1'b0;
          state <= S_ISSUE;
        end
        S_ISSUE: begin
          if (!col_end) begin
            col <= col + 1'b1;
          end else if (!sel_b) begin
            col   <= '0;
            sel_b <= 1'b1;
          end else if (!lag_end) begin
            col   <= '0;
            sel_b <= 1'b0;
            lag   <= lag + 1'b1;
          end else begin
            drain <= 1'b0;
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          drain <= 1'b1;
          if (drain) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            if (row_end) begin
              state <= S_SHIFT;
            end else begin
              row   <= row + 1'b1;
              state <= S_LOAD;
            end
          end
        end
        S_SHIFT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/maps_dp.sv]
// datapath: coefficient stores, histories and the multiply-accumulate unit
module maps_dp #(
  parameter int NUM_OUTPUTS = 4,
  parameter int NUM_INPUTS  = 4,
  parameter int MODEL_ORDER = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  maps_pkg::maps_cmd_t cmd,
  input  logic [2:0]          opcode,
  input  logic [5:0]          index,
  input  logic signed [31:0]  data_in,
  output logic [1:0]          out_row,
  output logic signed [31:0]  y_out,
  output logic                last_row
);
  import maps_pkg::*;

  localparam int LAG_W   = (MODEL_ORDER > 1) ? $clog2(MODEL_ORDER) : 1;
  localparam int ROW_W   = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
  localparam int IN_W    = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
  localparam int A_DEPTH = MODEL_ORDER * NUM_OUTPUTS * NUM_OUTPUTS;
  localparam int B_DEPTH = MODEL_ORDER * NUM_OUTPUTS * NUM_INPUTS;
  localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;

  logic signed [31:0] out_hist [MODEL_ORDER][NUM_OUTPUTS];
  logic signed [31:0] in_hist  [MODEL_ORDER][NUM_INPUTS];
  logic signed [31:0] offset_vec [NUM_OUTPUTS];
  logic signed [31:0] input_now  [NUM_INPUTS];
  logic signed [31:0] ynew       [NUM_OUTPUTS];
  logic [A_DEPTH-1:0] a_vld;
  logic [B_DEPTH-1:0] b_vld;

  logic [1:0]        w_lag;
  logic [1:0]        w_row;
  logic [1:0]        w_col;
  logic              a_we;
  logic              b_we;
  logic [A_AW-1:0]   a_waddr;
  logic [B_AW-1:0]   b_waddr;
  logic [A_AW-1:0]   a_raddr;
  logic [B_AW-1:0]   b_raddr;
  logic [31:0]       a_rd;
  logic [31:0]       b_rd;

  logic               s1_v;
  logic               s1_b;
  logic               s1_cv;
  logic signed [31:0] s1_h;
  logic signed [31:0] coef;
  logic signed [63:0] mul_q;
  logic signed [63:0] prod;
  logic               p_v;
  logic signed [63:0] rnd;
  logic signed [63:0] acc;
  logic signed [31:0] sat;

  // write decode from the item index
  assign w_lag   = index[5:4];
  assign w_row   = index[3:2];
  assign w_col   = index[1:0];
  assign a_we    = cmd.take && opcode == OP_WR_A && 32'(w_lag) < MODEL_ORDER &&
                   32'(w_row) < NUM_OUTPUTS && 32'(w_col) < NUM_OUTPUTS;
  assign b_we    = cmd.take && opcode == OP_WR_B && 32'(w_lag) < MODEL_ORDER &&
                   32'(w_row) < NUM_OUTPUTS && 32'(w_col) < NUM_INPUTS;
  assign a_waddr = A_AW'((32'(w_lag) * NUM_OUTPUTS + 32'(w_row)) * NUM_OUTPUTS + 32'(w_col));
  assign b_waddr = B_AW'((32'(w_lag) * NUM_OUTPUTS + 32'(w_row)) * NUM_INPUTS + 32'(w_col));
  assign a_raddr = A_AW'((32'(cmd.lag) * NUM_OUTPUTS + 32'(cmd.row)) * NUM_OUTPUTS
                         + 32'(cmd.col));
  assign b_raddr = B_AW'((32'(cmd.lag) * NUM_OUTPUTS + 32'(cmd.row)) * NUM_INPUTS
                         + 32'(cmd.col));

  maps_ram #(.WIDTH(32), .DEPTH(A_DEPTH)) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (data_in),
    .raddr (a_raddr),
    .rdata (a_rd)
  );

  maps_ram #(.WIDTH(32), .DEPTH(B_DEPTH)) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (data_in),
    .raddr (b_raddr),
    .rdata (b_rd)
  );

  // coefficient valid bits, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= '0;
      b_vld <= '0;
    end else begin
      if (a_we) a_vld[a_waddr] <= 1'b1;
      if (b_we) b_vld[b_waddr] <= 1'b1;
    end
  end

  // small state: offsets, current input, histories
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MODEL_ORDER; k++) begin
        for (int r = 0; r < NUM_OUTPUTS; r++) out_hist[k][r] <= '0;
        for (int c = 0; c < NUM_INPUTS; c++) in_hist[k][c] <= '0;
      end
      for (int r = 0; r < NUM_OUTPUTS; r++) offset_vec[r] <= '0;
      for (int c = 0; c < NUM_INPUTS; c++) input_now[c] <= '0;
    end else begin
      if (cmd.take) begin
        case (opcode)
          OP_WR_OFS: if (32'(index) < NUM_OUTPUTS) offset_vec[index[ROW_W-1:0]] <= data_in;
          OP_SET_IN: if (32'(index) < NUM_INPUTS) input_now[index[IN_W-1:0]] <= data_in;
          OP_PRESET: begin
            if (32'(index) < NUM_OUTPUTS) begin
              for (int k = 0; k < MODEL_ORDER; k++) out_hist[k][index[ROW_W-1:0]] <= data_in;
            end
          end
          OP_TICK: begin
            for (int k = MODEL_ORDER - 1; k > 0; k--) in_hist[k] <= in_hist[k-1];
            in_hist[0] <= input_now;
          end
          default: ;
        endcase
      end
      if (cmd.hist_shift) begin
        for (int k = MODEL_ORDER - 1; k > 0; k--) out_hist[k] <= out_hist[k-1];
        out_hist[0] <= ynew;
      end
    end
  end

  // issue stage: history operand beside the ram read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= cmd.issue;
    end
    s1_b  <= cmd.sel_b;
    s1_cv <= cmd.sel_b ? b_vld[b_raddr] : a_vld[a_raddr];
    s1_h  <= cmd.sel_b ? in_hist[cmd.lag[LAG_W-1:0]][cmd.col[IN_W-1:0]]
                       : out_hist[cmd.lag[LAG_W-1:0]][cmd.col[ROW_W-1:0]];
  end

  // multiply stage
  assign coef  = s1_cv ? (s1_b ? signed'(b_rd) : signed'(a_rd)) : 32'sd0;
  assign mul_q = coef * s1_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else begin
      p_v <= s1_v;
    end
    prod <= mul_q;
  end

  // round half up to q16.16 and accumulate
  assign rnd = (prod + 64'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    if (cmd.acc_load) begin
      acc <= {{32{offset_vec[cmd.row[ROW_W-1:0]][31]}}, offset_vec[cmd.row[ROW_W-1:0]]};
    end else if (p_v) begin
      acc <= acc + rnd;
    end
  end

  // saturate to 32 bits
  always_comb begin
    if (acc > 64'sd2147483647) begin
      sat = 32'sh7fffffff;
    end else if (acc < -64'sd2147483648) begin
      sat = 32'sh80000000;
    end else begin
      sat = acc[31:0];
    end
  end

  // result register and new output vector
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      y_out                     <= sat;
      out_row                   <= cmd.row[1:0];
      last_row                  <= cmd.last;
      ynew[cmd.row[ROW_W-1:0]]  <= sat;
    end
  end

endmodule

[hw/rtl/mimo_arx_plant_step_unit.sv]
// top level of the multi-input multi-output difference-equation plant
// A non-tick item (coefficient, offset, input or preset write) is applied
// when it is taken, and the block stays ready for the next. A tick is worked
// by the single multiply-accumulate unit, which takes one Q16.16 product
// per cycle from the coefficient rams; each output row adds an accumulator
// load, a pipeline drain and a result beat, and a longer wait if the
// previous result beat has not been taken. One item is worked on at a time;
// a new item is taken while the last result beat of a tick still waits at
// the output register.
module mimo_arx_plant_step_unit #(
  parameter int NUM_OUTPUTS = 4,
  parameter int NUM_INPUTS  = 4,
  parameter int MODEL_ORDER = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         opcode,
  input  logic [5:0]         index,
  input  logic signed [31:0] data_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_row,
  output logic signed [31:0] y_out,
  output logic               last_row
);
  import maps_pkg::*;

  maps_cmd_t cmd;

  maps_ctrl #(
    .NUM_OUTPUTS (NUM_OUTPUTS),
    .NUM_INPUTS  (NUM_INPUTS),
    .MODEL_ORDER (MODEL_ORDER)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  maps_dp #(
    .NUM_OUTPUTS (NUM_OUTPUTS),
    .NUM_INPUTS  (NUM_INPUTS),
    .MODEL_ORDER (MODEL_ORDER)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .opcode   (opcode),
    .index    (index),
    .data_in  (data_in),
    .out_row  (out_row),
    .y_out    (y_out),
    .last_row (last_row)
  );

endmodule

[hw/rtl/maps_chk.sv]
// port-level checks for the plant unit, bound to the top level
module maps_chk #(
  parameter int NUM_OUTPUTS = 4
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [2:0]         opcode,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_row,
  input logic signed [31:0] y_out,
  input logic               last_row
);
  import maps_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(y_out) && $stable(out_row))
    else $error("result beat changed while stalled");

  // the block stays busy between rows of one tick
  a_busy_rows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_row |-> !in_ready)
    else $error("input taken in the middle of a tick");

  // a tick is never followed at once by another input beat
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode == OP_TICK |=> !in_ready)
    else $error("input ready right after a tick");

  // the last row mark sits on the final row
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_row |-> out_row == 2'(NUM_OUTPUTS - 1))
    else $error("last row mark on wrong row");

endmodule

bind mimo_arx_plant_step_unit maps_chk #(.NUM_OUTPUTS(NUM_OUTPUTS)) u_maps_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .opcode    (opcode),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_row   (out_row),
  .y_out     (y_out),
  .last_row  (last_row)
);

[test/mimo_arx_plant_step_unit_test.sv]
// self-checking bench for the difference-equation plant step unit
`timescale 1ns / 100ps

module mimo_arx_plant_step_unit_test;
  import maps_pkg::*;

  localparam int N_OUT = 4;
  localparam int N_IN = 4;
  localparam int ORDER = 4;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]         op;
    logic [5:0]         idx;
    logic signed [31:0] data;
  } plant_item_t;

  typedef struct packed {
    logic [1:0]         row;
    logic signed [31:0] y;
    logic               last;
  } plant_row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         opcode;
  logic [5:0]         index;
  logic signed [31:0] data_in;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_row;
  logic signed [31:0] y_out;
  logic               last_row;

  // predictor state
  logic signed [31:0] coef_a [ORDER][N_OUT][N_OUT];
  logic signed [31:0] coef_b [ORDER][N_OUT][N_IN];
  logic signed [31:0] ofs_vec [N_OUT];
  logic signed [31:0] u_now [N_IN];
  logic signed [31:0] y_hist [ORDER][N_OUT];
  logic signed [31:0] u_hist [ORDER][N_IN];

  plant_item_t pending_items[$];
  plant_row_t  expected_rows[$];
  int  n_errors;
  int  n_queued;
  int  idle_cycles;
  bit  rx_hold;
  bit  tx_pause;
  bit  no_idle;
  bit  done;

  mimo_arx_plant_step_unit #(
    .NUM_OUTPUTS(N_OUT),
    .NUM_INPUTS (N_IN),
    .MODEL_ORDER(ORDER)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .index    (index),
    .data_in  (data_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_row  (out_row),
    .y_out    (y_out),
    .last_row (last_row)
  );

  // clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // q16.16 product rounded half up
  function automatic logic signed [63:0] q16_product(logic signed [31:0] a,
                                                     logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd32768;
    return p >>> 16;
  endfunction

  // apply one beat to the predicted plant, queue any output rows
  task automatic plant_predict(plant_item_t it);
    int lag;
    int rw;
    int cl;
    logic signed [63:0] acc;
    logic signed [31:0] y_new [N_OUT];
    plant_row_t res;
    lag = it.idx[5:4];
    rw = it.idx[3:2];
    cl = it.idx[1:0];
    case (it.op)
      OP_WR_A: coef_a[lag][rw][cl] = it.data;
      OP_WR_B: coef_b[lag][rw][cl] = it.data;
      OP_WR_OFS: if (it.idx < N_OUT) ofs_vec[it.idx] = it.data;
      OP_SET_IN: if (it.idx < N_IN) u_now[it.idx] = it.data;
      OP_PRESET: if (it.idx < N_OUT) for (int k = 0; k < ORDER; k++) y_hist[k][it.idx] = it.data;
      OP_TICK: begin
        for (int k = ORDER - 1; k > 0; k--) u_hist[k] = u_hist[k-1];
        u_hist[0] = u_now;
        for (int r = 0; r < N_OUT; r++) begin
          acc = 64'(ofs_vec[r]);
          for (int k = 0; k < ORDER; k++) begin
            for (int c = 0; c < N_OUT; c++) acc += q16_product(coef_a[k][r][c], y_hist[k][c]);
            for (int c = 0; c < N_IN; c++) acc += q16_product(coef_b[k][r][c], u_hist[k][c]);
          end
          if (acc > 64'sd2147483647) y_new[r] = 32'sh7fffffff;
          else if (acc < -64'sd2147483648) y_new[r] = 32'sh80000000;
          else y_new[r] = acc[31:0];
        end
        for (int k = ORDER - 1; k > 0; k--) y_hist[k] = y_hist[k-1];
        y_hist[0] = y_new;
        for (int r = 0; r < N_OUT; r++) begin
          res.row = 2'(r);
          res.y = y_new[r];
          res.last = (r == N_OUT - 1);
          expected_rows = {expected_rows, res};
        end
      end
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'($urandom_range(0, 131072)) - 32'sd65536;
      3: return 32'($urandom_range(0, 16384)) - 32'sd8192;
      default: return $urandom;
    endcase
  endfunction

  function automatic plant_item_t make_item(logic [2:0] op, logic [5:0] idx,
                                            logic signed [31:0] d);
    plant_item_t it;
    it.op = op;
    it.idx = idx;
    it.data = d;
    return it;
  endfunction

  // append one item to the pending queue
  task automatic queue_item(plant_item_t it);
    pending_items = {pending_items, it};
    n_queued++;
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      opcode <= '0;
      index <= '0;
      data_in <= '0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) plant_predict(make_item(opcode, index, data_in));
      if (pending_items.size() > 0 && !tx_pause &&
          (no_idle || $urandom_range(0, 99) >= 7)) begin
        plant_item_t it;
        it = pending_items.pop_front();
        in_valid <= 1'b1;
        opcode <= it.op;
        index <= it.idx;
        data_in <= it.data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output ready and result check
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rows.size() == 0) begin
          $display("%0t: unexpected row %0d y %0d last %0b", $time, out_row, y_out, last_row);
          n_errors++;
        end else begin
          plant_row_t ex;
          ex = expected_rows.pop_front();
          if (out_row !== ex.row) begin
            $display("%0t: out_row expected %0d actual %0d", $time, ex.row, out_row);
            n_errors++;
          end
          if (y_out !== ex.y) begin
            $display("%0t: y_out expected %0d actual %0d", $time, ex.y, y_out);
            n_errors++;
          end
          if (last_row !== ex.last) begin
            $display("%0t: last_row expected %0b actual %0b", $time, ex.last, last_row);
            n_errors++;
          end
        end
      end
      out_ready <= !rx_hold && (no_idle || $urandom_range(0, 99) >= 7);
    end
  end

  // watchdog on cycles with no beat
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!done && idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic queue_tick_burst(bit wide);
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1: queue_item(make_item(OP_WR_A, 6'($urandom), wide ? rand_value() :
                                   32'($urandom_range(0, 32768)) - 32'sd16384));
        2, 3: queue_item(make_item(OP_WR_B, 6'($urandom), rand_value()));
        4: queue_item(make_item(OP_WR_OFS, 6'($urandom_range(0, 5)), rand_value()));
        5, 6: queue_item(make_item(OP_SET_IN, 6'($urandom_range(0, 5)), rand_value()));
        7: queue_item(make_item(OP_PRESET, 6'($urandom_range(0, 5)), rand_value()));
        8: queue_item(make_item(3'($urandom_range(6, 7)), 6'($urandom), $urandom));
        default: queue_item(make_item(3'($urandom_range(0, 4)), 6'($urandom), $urandom));
      endcase
    end
    queue_item(make_item(OP_TICK, 6'($urandom), $urandom));
  endtask

  // stimulus
  initial begin
    coef_a = '{default: '0};
    coef_b = '{default: '0};
    ofs_vec = '{default: '0};
    u_now = '{default: '0};
    y_hist = '{default: '0};
    u_hist = '{default: '0};
    n_errors = 0;
    n_queued = 0;
    rx_hold = 0;
    tx_pause = 0;
    no_idle = 0;
    done = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    opcode = '0;
    index = '0;
    data_in = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: reset state, extremes, saturation, ignored writes
    queue_item(make_item(OP_TICK, 6'd0, 32'sd0));
    queue_item(make_item(OP_WR_A, 6'd0, 32'sh7fffffff));
    queue_item(make_item(OP_PRESET, 6'd0, 32'sh7fffffff));
    queue_item(make_item(OP_WR_A, 6'd4, 32'sh80000000));
    queue_item(make_item(OP_PRESET, 6'd1, 32'sh7fffffff));
    queue_item(make_item(OP_WR_B, 6'd63, 32'sh00010000));
    queue_item(make_item(OP_SET_IN, 6'd3, 32'sh80000000));
    queue_item(make_item(OP_WR_OFS, 6'd3, 32'sh7fffffff));
    queue_item(make_item(OP_WR_OFS, 6'd63, 32'sh12345678));
    queue_item(make_item(OP_SET_IN, 6'd4, 32'sh0000ffff));
    queue_item(make_item(OP_PRESET, 6'd63, 32'sh7fffffff));
    queue_item(make_item(3'd6, 6'd0, 32'sh7fffffff));
    queue_item(make_item(3'd7, 6'd63, 32'shffffffff));
    queue_item(make_item(OP_TICK, 6'd63, 32'shffffffff));
    queue_item(make_item(OP_WR_B, 6'd0, 32'sh00008000));
    queue_item(make_item(OP_SET_IN, 6'd0, 32'sh00000001));
    queue_item(make_item(OP_TICK, 6'd0, 32'sd0));
    queue_item(make_item(OP_SET_IN, 6'd0, -32'sd1));
    queue_item(make_item(OP_TICK, 6'd0, 32'sd0));
    queue_item(make_item(OP_TICK, 6'd0, 32'sd0));

    // receiver holds off while the sender keeps offering
    rx_hold = 1;
    for (int i = 0; i < 4; i++) queue_tick_burst(1);
    repeat (1500) @(posedge clk);
    rx_hold = 0;

    // sender waits for the block to drain
    wait (pending_items.size() == 0);
    tx_pause = 1;
    wait (expected_rows.size() == 0 && !in_valid);
    repeat (200) @(posedge clk);
    tx_pause = 0;

    // random, with a stretch free of idling
    while (n_queued < 450) begin
      queue_tick_burst($urandom_range(0, 3) == 0);
      no_idle = (n_queued > 200 && n_queued < 300);
      wait (pending_items.size() < 4);
    end
    no_idle = 0;

    wait (pending_items.size() == 0 && !in_valid);
    wait (expected_rows.size() == 0);
    repeat (300) @(posedge clk);
    done = 1;
    if (n_errors == 0 && expected_rows.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
